// ----- hw/rtl/ukf_pkg.sv -----
`timescale 1ns / 1ps
// ukf_pkg: shared types and codes for the unique-key FIFO.
// No dependencies; used by ukf_cell, unique_key_fifo_unit and ukf_checker.

package ukf_pkg;

  localparam int DEPTH_DEF = 4;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 3;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Per-cell control
  typedef struct packed {
    logic shift;  // take the key of the younger neighbor (pop)
    logic load;   // capture the pushed key (this cell is the tail)
  } cell_ctl_t;

endpackage

// ----- hw/rtl/ukf_cell.sv -----
`timescale 1ns / 1ps
// ukf_cell: one slot of the key chain; holds a key and compares it.
// Depends on ukf_pkg.

module ukf_cell (
  input  logic                     clk,
  input  ukf_pkg::cell_ctl_t       ctl,
  input  logic                     live,      // slot holds a queued key
  input  logic [ukf_pkg::KEY_W-1:0] push_key,
  input  logic [ukf_pkg::KEY_W-1:0] next_key, // key of the younger neighbor
  input  logic [ukf_pkg::KEY_W-1:0] cmp_key,
  output logic [ukf_pkg::KEY_W-1:0] key_q,
  output logic                     match
);

  logic [ukf_pkg::KEY_W-1:0] key_r;
  logic [ukf_pkg::KEY_W-1:0] key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = push_key;
    end else if (ctl.shift) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;
  assign match = live && (key_r == cmp_key);

endmodule

// ----- hw/rtl/unique_key_fifo_unit.sv -----
`timescale 1ns / 1ps
// unique_key_fifo_unit: FIFO of 32-bit keys that refuses duplicate pushes.
// Depends on ukf_pkg and ukf_cell.
//
//  channel | dir | fields (low bit first)
//  --------+-----+--------------------------------------------------------
//  in_     | in  | op[1:0], key[33:2], zero pad [39:34]
//  out_    | out | status[1:0], popped_key[33:2], found[34], occupancy[37:35],
//          |     | zero pad [39:38]
//
// One word per cycle unless out_ stalls: a word is accepted, decoded and the
// result registered in the same cycle. The longest path is the key compare in
// every cell and the OR over all match bits, which feeds the push decision.
// in_tready stays high while the output register is empty or being drained,
// so a stall on out_ holds back at most one result.
// Synchronous active-low reset empties the queue; stored keys are not cleared.

module unique_key_fifo_unit #(
  parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ukf_pkg::IN_TDATA_W-1:0]  in_tdata,   // op, key
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ukf_pkg::OUT_TDATA_W-1:0] out_tdata   // status, popped_key, found, occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  // Queue is kept in age order: cell 0 is the oldest key, cell count-1 the
  // newest. A pop shifts every key one cell toward 0; a push writes cell count.
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic                            out_valid_r;
  logic [ukf_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [ukf_pkg::OP_W-1:0]  op;
  logic [ukf_pkg::KEY_W-1:0] key;
  logic                      accept;

  logic [ukf_pkg::KEY_W-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]          match;
  logic                      hit;
  logic                      full;
  logic                      empty;
  logic                      push_ok;
  logic                      pop_ok;

  logic [ukf_pkg::STATUS_W-1:0] status;
  logic [ukf_pkg::KEY_W-1:0]    popped_key;
  logic                         found;
  logic [CW+2:0]                count_ext;
  logic [ukf_pkg::OCC_W-1:0]    occupancy;

  assign op     = in_tdata[ukf_pkg::OP_W-1:0];
  assign key    = in_tdata[ukf_pkg::OP_W +: ukf_pkg::KEY_W];
  assign accept = in_tvalid && in_tready;

  assign in_tready = !out_valid_r || out_tready;

  assign hit   = |match;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign push_ok = accept && (op == ukf_pkg::OP_PUSH) && !full && !hit;
  assign pop_ok  = accept && (op == ukf_pkg::OP_POP) && !empty;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ukf_pkg::cell_ctl_t        ctl;
    logic [ukf_pkg::KEY_W-1:0] next_key;

    assign ctl.shift = pop_ok;
    assign ctl.load  = push_ok && (count_r == CW'(i));

    if (i == DEPTH - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_mid
      assign next_key = cell_key[i+1];
    end

    ukf_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .live     (count_r > CW'(i)),
      .push_key (key),
      .next_key (next_key),
      .cmp_key  (key),
      .key_q    (cell_key[i]),
      .match    (match[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Result decode
  always_comb begin
    status     = ukf_pkg::ST_OK;
    popped_key = '0;
    found      = 1'b0;
    case (op)
      ukf_pkg::OP_PUSH: begin
        found = hit;
        if (full) begin
          status = ukf_pkg::ST_FULL;   // full wins over duplicate
        end else if (hit) begin
          status = ukf_pkg::ST_DUP;
        end
      end
      ukf_pkg::OP_POP: begin
        if (empty) begin
          status = ukf_pkg::ST_EMPTY;
        end else begin
          popped_key = cell_key[0];
        end
      end
      ukf_pkg::OP_LOOKUP: begin
        found = hit;
      end
      default: begin
        // unused op: no change, plain result
      end
    endcase
  end

  // occupancy is the count after the op, low three bits
  assign count_ext = {3'b000, count_nxt};
  assign occupancy = count_ext[ukf_pkg::OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {2'b00, occupancy, found, popped_key, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/ukf_checker.sv -----
`timescale 1ns / 1ps
// ukf_checker: port-level checks for unique_key_fifo_unit, bound to the top.
// Depends on ukf_pkg.

module ukf_checker #(
  parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ukf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [ukf_pkg::STATUS_W-1:0] status;
  logic [ukf_pkg::KEY_W-1:0]    popped_key;
  logic [ukf_pkg::OCC_W-1:0]    occupancy;

  assign status     = out_tdata[1:0];
  assign popped_key = out_tdata[33:2];
  assign occupancy  = out_tdata[37:35];

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out word changed under stall");

  // every accepted word gives a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no result");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ukf_pkg::ST_EMPTY) |-> (occupancy == '0) && (popped_key == '0))
    else $error("empty pop with nonzero occupancy or key");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ukf_pkg::ST_FULL) |-> (occupancy == 3'(DEPTH)))
    else $error("full push with wrong occupancy");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH >= 8) || (32'(occupancy) <= DEPTH))
    else $error("occupancy above depth");

endmodule

bind unique_key_fifo_unit ukf_checker #(.DEPTH(DEPTH)) u_ukf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
